/* sv/pvti_pkg.sv */
`default_nettype none

package pvti_pkg;

    localparam int FRAC_BITS      = 20;
    localparam int RECIP_LAST_COL = 4;

    // shared divider geometry: unsigned magnitudes, 32 quotient bits a pass
    localparam int DIV_NUM_W = 53;
    localparam int DIV_DEN_W = 33;
    localparam int DIV_Q_W   = 32;

    localparam logic [0:0] OP_LOAD   = 1'b0;
    localparam logic [0:0] OP_LOOKUP = 1'b1;

    localparam logic [2:0] COL_PRESSURE = 3'd0;

    localparam logic [0:0] REG_INTERVAL_COUNT = 1'b0;

    localparam logic signed [31:0] SAT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic               ovf;
        logic [DIV_Q_W-1:0] quo;
    } t_div_rsp;

    // apply sign to an unsigned quotient and clamp to signed 32 bits
    function automatic logic signed [31:0] f_sat(input logic neg,
                                                 input logic [DIV_Q_W-1:0] quo,
                                                 input logic ovf);
        logic signed [31:0] res;
        if (ovf || quo[DIV_Q_W-1]) begin
            res = neg ? SAT_MIN : SAT_MAX;
        end else if (neg) begin
            res = -$signed(quo);
        end else begin
            res = $signed(quo);
        end
        return res;
    endfunction

endpackage

`default_nettype wire

/* sv/pvt_table_interval_interpolator.sv */
`default_nettype none

// Channel   | Dir | Handshake            | Payload
// ----------+-----+----------------------+-----------------------------------------
// s (item)  | in  | i_s_tvalid/o_s_tready| tdata: row,column,entry_value,
//           |     |                      |        query_pressure,full_search; tuser: opcode
// m (item)  | out | o_m_tvalid/i_m_tready| tdata: interval,interp_value,slope; tuser: found
// APB       | in  | psel/penable/pready  | reg 0 interval_count at byte address 0
//
// One item at a time; o_s_tready is high only while the sequencer is idle.
// A load writes the table and goes straight to the output stage. A lookup
// probes intervals (last interval, up to 2*SEARCH_WINDOW neighbors, then
// about log2(TABLE_ROWS)+1 bisection probes) with a neighbor step between
// neighbor probes, then reads the properties and makes up to five passes
// of the shared divider (fraction, three reciprocals, slope); each
// reciprocal first goes through S_RCP, which saturates a zero operand.
// A finished item sits in the output register while the next one is taken.
// Reset is synchronous; table memories are not cleared and must be loaded.
module pvt_table_interval_interpolator #(
    parameter int TABLE_ROWS    = 1024,
    parameter int SEARCH_WINDOW = 4,
    parameter int ROW_STRIDE    = 6
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    // [9:0] row, [12:10] column, [44:13] entry_value,
    // [76:45] query_pressure, [77] full_search, [79:78] zero
    input  wire  [79:0] i_s_tdata,
    // [0] opcode
    input  wire  [0:0]  i_s_tuser,
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    // [9:0] interval, [41:10] interp_value, [73:42] slope, [79:74] zero
    output logic [79:0] o_m_tdata,
    // [0] found
    output logic [0:0]  o_m_tuser,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW  = $clog2(TABLE_ROWS);
    localparam int PD  = TABLE_ROWS * (ROW_STRIDE - 1);
    localparam int PAW = $clog2(PD);
    localparam int IW  = $clog2(SEARCH_WINDOW + 1);
    localparam int NMAX = TABLE_ROWS - 1;

    typedef enum logic [3:0] {
        S_IDLE, S_CHK0, S_CHK1, S_CHK2, S_NBR, S_FOUND, S_V0, S_V1, S_V2,
        S_MUL, S_ADDU, S_RCP, S_DIVGO, S_DIVW, S_DONE
    } t_state;
    typedef enum logic [1:0] {M_CUR, M_NBR, M_BIS, M_FIN} t_mode;
    typedef enum logic [2:0] {D_T, D_RU, D_R0, D_R1, D_SL} t_dop;

    // input fields
    logic [9:0]         w_row;
    logic [2:0]         w_col;
    logic signed [31:0] w_entry;
    logic signed [31:0] w_query;
    logic               w_full;
    logic               w_acc;
    assign w_row   = i_s_tdata[9:0];
    assign w_col   = i_s_tdata[12:10];
    assign w_entry = i_s_tdata[44:13];
    assign w_query = i_s_tdata[76:45];
    assign w_full  = i_s_tdata[77];
    assign w_acc   = i_s_tvalid && o_s_tready;

    // config
    logic [9:0] r_cnt;
    logic       w_cfg_wr;
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign prdata   = (paddr[2] == pvti_pkg::REG_INTERVAL_COUNT) ? {22'b0, r_cnt} : 32'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 10'd1023;
        end else if (w_cfg_wr && paddr[2] == pvti_pkg::REG_INTERVAL_COUNT) begin
            r_cnt <= pwdata[9:0];
        end
    end

    // clamped interval count
    logic [AW-1:0] w_n;
    always_comb begin
        if (r_cnt == 10'd0) begin
            w_n = AW'(1);
        end else if (32'(r_cnt) > 32'(NMAX)) begin
            w_n = AW'(NMAX);
        end else begin
            w_n = AW'(r_cnt);
        end
    end

    t_state             r_state;
    t_mode              r_mode;
    t_dop               r_dop;
    logic [AW-1:0]      r_k, r_cur, r_lo, r_hi, r_n;
    logic [IW-1:0]      r_i;
    logic               r_dir;
    logic               r_found;
    logic [2:0]         r_col;
    logic signed [31:0] r_p, r_p0, r_p1, r_pq, r_vq, r_v0, r_v1;
    logic signed [31:0] r_u, r_r0, r_r1, r_value, r_slope;
    logic [20:0]        r_t;
    logic signed [53:0] r_prod;
    logic [9:0]         r_oint;
    logic               r_mvalid;
    logic [79:0]        r_mdata;
    logic               r_muser;

    // table memories
    logic signed [31:0] r_pmem [TABLE_ROWS];
    logic signed [31:0] r_vmem [PD];
    logic [AW-1:0]      w_paddr;
    logic [PAW-1:0]     w_vaddr;
    logic [PAW-1:0]     w_ld_vaddr;
    logic               w_ld_ok;

    assign w_ld_ok    = (32'(w_row) < 32'(TABLE_ROWS)) && (32'(w_col) < 32'(ROW_STRIDE));
    assign w_ld_vaddr = PAW'(32'(w_row) * (ROW_STRIDE - 1) + 32'(w_col) - 32'd1);
    assign w_paddr    = (r_state == S_CHK1) ? AW'(32'(r_k) + 32'd1) : r_k;
    assign w_vaddr    = (r_state == S_V1)
                        ? PAW'((32'(r_k) + 32'd1) * (ROW_STRIDE - 1) + 32'(r_col) - 32'd1)
                        : PAW'(32'(r_k) * (ROW_STRIDE - 1) + 32'(r_col) - 32'd1);

    always_ff @(posedge i_clk) begin
        if (w_acc && i_s_tuser == pvti_pkg::OP_LOAD && w_ld_ok
            && w_col == pvti_pkg::COL_PRESSURE) begin
            r_pmem[AW'(w_row)] <= w_entry;
        end
        r_pq <= r_pmem[w_paddr];
    end

    always_ff @(posedge i_clk) begin
        if (w_acc && i_s_tuser == pvti_pkg::OP_LOAD && w_ld_ok
            && w_col != pvti_pkg::COL_PRESSURE) begin
            r_vmem[w_ld_vaddr] <= w_entry;
        end
        r_vq <= r_vmem[w_vaddr];
    end

    // interval tests: r_p0 = P[k], r_pq = P[k+1] in S_CHK2
    logic w_closed, w_half;
    assign w_closed = (r_p >= r_p0) && (r_p <= r_pq);
    assign w_half   = (r_p > r_p0) && (r_p <= r_pq);

    logic [AW-1:0] w_lo_n, w_hi_n, w_mid;
    assign w_lo_n = (r_p > r_pq) ? r_k : r_lo;
    assign w_hi_n = (r_p <= r_p0) ? r_k : r_hi;
    assign w_mid  = AW'(({1'b0, w_lo_n} + {1'b0, w_hi_n}) >> 1);

    logic w_nbr_stop;
    assign w_nbr_stop = (r_i == IW'(SEARCH_WINDOW))
                        || (32'(r_cur) + 32'(r_i) + 32'd2 > 32'(r_n))
                        || (32'(r_cur) < 32'(r_i) + 32'd1);

    logic w_colok, w_recip;
    assign w_colok = (r_col != pvti_pkg::COL_PRESSURE) && (32'(r_col) < 32'(ROW_STRIDE));
    assign w_recip = 32'(r_col) <= 32'(pvti_pkg::RECIP_LAST_COL);

    // arithmetic
    logic signed [32:0] w_dp, w_pdiff, w_vdiff, w_rdiff, w_sdiff;
    logic               w_dp_pos;
    logic signed [33:0] w_step;
    logic signed [31:0] w_u, w_x;
    assign w_dp     = {r_p1[31], r_p1} - {r_p0[31], r_p0};
    assign w_dp_pos = !w_dp[32] && (w_dp != '0);
    assign w_pdiff  = {r_p[31], r_p} - {r_p0[31], r_p0};
    assign w_vdiff  = {r_v1[31], r_v1} - {r_v0[31], r_v0};
    assign w_rdiff  = {r_r1[31], r_r1} - {r_r0[31], r_r0};
    assign w_sdiff  = w_recip ? w_rdiff : w_vdiff;
    assign w_step   = 34'(r_prod >>> pvti_pkg::FRAC_BITS);
    assign w_u      = 32'(34'(r_v0) + w_step);

    always_comb begin
        unique case (r_dop)
            D_RU:    w_x = r_u;
            D_R0:    w_x = r_v0;
            default: w_x = r_v1;
        endcase
    end

    // shared divider requests
    pvti_pkg::t_div_req w_req;
    pvti_pkg::t_div_rsp w_rsp;
    logic               w_neg;
    logic [32:0]        w_xmag, w_smag;
    assign w_xmag = w_x[31] ? -{w_x[31], w_x} : {w_x[31], w_x};
    assign w_smag = w_sdiff[32] ? -w_sdiff : w_sdiff;

    always_comb begin
        w_req.start = (r_state == S_DIVGO);
        unique case (r_dop)
            D_T: begin
                w_req.num = {w_pdiff, 20'b0};
                w_req.den = w_dp;
                w_neg     = 1'b0;
            end
            D_SL: begin
                w_req.num = {w_smag, 20'b0};
                w_req.den = w_dp;
                w_neg     = w_sdiff[32];
            end
            default: begin
                w_req.num = {12'b0, 1'b1, 40'b0};
                w_req.den = w_xmag;
                w_neg     = w_x[31];
            end
        endcase
    end

    pvti_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    // a division result, or a reciprocal of zero taken without dividing
    logic               w_fin;
    logic signed [31:0] w_res;
    assign w_fin = (r_state == S_DIVW && w_rsp.done) || (r_state == S_RCP && w_x == '0);
    assign w_res = (r_state == S_RCP) ? pvti_pkg::SAT_MAX
                                      : pvti_pkg::f_sat(w_neg, w_rsp.quo, w_rsp.ovf);

    // finished item moves into the output register
    logic w_out_load;
    assign w_out_load = (r_state == S_DONE) && (!r_mvalid || i_m_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cur    <= '0;
            r_mvalid <= 1'b0;
        end else begin
            if (w_out_load) begin
                r_mvalid <= 1'b1;
            end else if (r_mvalid && i_m_tready) begin
                r_mvalid <= 1'b0;
            end
            if (w_fin) begin
                unique case (r_dop)
                    D_T: begin
                        r_t     <= w_rsp.quo[20:0];
                        r_state <= S_MUL;
                    end
                    D_RU: begin
                        r_value <= w_res;
                        if (w_dp_pos) begin
                            r_dop   <= D_R0;
                            r_state <= S_RCP;
                        end else begin
                            r_slope <= '0;
                            r_state <= S_DONE;
                        end
                    end
                    D_R0: begin
                        r_r0    <= w_res;
                        r_dop   <= D_R1;
                        r_state <= S_RCP;
                    end
                    D_R1: begin
                        r_r1    <= w_res;
                        r_dop   <= D_SL;
                        r_state <= S_DIVGO;
                    end
                    default: begin
                        r_slope <= w_res;
                        r_state <= S_DONE;
                    end
                endcase
            end else begin
                unique case (r_state)
                    S_IDLE: begin
                        if (w_acc) begin
                            r_col  <= w_col;
                            r_p    <= w_query;
                            r_n    <= w_n;
                            if (i_s_tuser == pvti_pkg::OP_LOAD) begin
                                r_oint  <= '0;
                                r_value <= '0;
                                r_slope <= '0;
                                r_found <= w_ld_ok;
                                r_state <= S_DONE;
                            end else begin
                                r_found <= 1'b0;
                                if (!w_full && r_cur < w_n) begin
                                    r_k    <= r_cur;
                                    r_mode <= M_CUR;
                                end else begin
                                    r_lo   <= '0;
                                    r_hi   <= w_n;
                                    r_k    <= w_n >> 1;
                                    r_mode <= M_BIS;
                                end
                                r_state <= S_CHK0;
                            end
                        end
                    end
                    S_CHK0: r_state <= S_CHK1;
                    S_CHK1: begin
                        r_p0    <= r_pq;
                        r_state <= S_CHK2;
                    end
                    S_CHK2: begin
                        r_p1 <= r_pq;
                        unique case (r_mode)
                            M_CUR, M_NBR: begin
                                if (w_closed) begin
                                    r_found <= 1'b1;
                                    r_state <= S_FOUND;
                                end else if (r_mode == M_CUR) begin
                                    r_i     <= '0;
                                    r_dir   <= 1'b0;
                                    r_state <= S_NBR;
                                end else if (!r_dir) begin
                                    r_dir   <= 1'b1;
                                    r_k     <= AW'(32'(r_cur) - 32'(r_i) - 32'd1);
                                    r_state <= S_CHK0;
                                end else begin
                                    r_i     <= r_i + IW'(1);
                                    r_dir   <= 1'b0;
                                    r_state <= S_NBR;
                                end
                            end
                            M_BIS: begin
                                if (w_half) begin
                                    r_found <= 1'b1;
                                    r_state <= S_FOUND;
                                end else begin
                                    r_lo    <= w_lo_n;
                                    r_hi    <= w_hi_n;
                                    r_k     <= w_mid;
                                    if (w_mid == w_lo_n) begin
                                        r_mode <= M_FIN;
                                    end
                                    r_state <= S_CHK0;
                                end
                            end
                            default: begin
                                r_found <= w_half;
                                r_state <= S_FOUND;
                            end
                        endcase
                    end
                    S_NBR: begin
                        if (w_nbr_stop) begin
                            r_lo   <= '0;
                            r_hi   <= r_n;
                            r_k    <= r_n >> 1;
                            r_mode <= M_BIS;
                        end else begin
                            r_k    <= AW'(32'(r_cur) + 32'(r_i) + 32'd1);
                            r_mode <= M_NBR;
                        end
                        r_state <= S_CHK0;
                    end
                    S_FOUND: begin
                        r_cur  <= r_k;
                        r_oint <= 10'(r_k);
                        if (r_found && w_colok) begin
                            r_state <= S_V0;
                        end else begin
                            r_value <= '0;
                            r_slope <= '0;
                            r_state <= S_DONE;
                        end
                    end
                    S_V0: r_state <= S_V1;
                    S_V1: begin
                        r_v0    <= r_vq;
                        r_state <= S_V2;
                    end
                    S_V2: begin
                        r_v1 <= r_vq;
                        if (w_dp_pos) begin
                            r_dop   <= D_T;
                            r_state <= S_DIVGO;
                        end else begin
                            r_t     <= '0;
                            r_state <= S_MUL;
                        end
                    end
                    S_MUL: begin
                        r_prod  <= w_vdiff * $signed({1'b0, r_t});
                        r_state <= S_ADDU;
                    end
                    S_ADDU: begin
                        r_u <= w_u;
                        if (w_recip) begin
                            r_dop   <= D_RU;
                            r_state <= S_RCP;
                        end else begin
                            r_value <= w_u;
                            if (w_dp_pos) begin
                                r_dop   <= D_SL;
                                r_state <= S_DIVGO;
                            end else begin
                                r_slope <= '0;
                                r_state <= S_DONE;
                            end
                        end
                    end
                    S_RCP:   r_state <= S_DIVGO;  // nonzero operand
                    S_DIVGO: r_state <= S_DIVW;
                    S_DIVW:  r_state <= S_DIVW;
                    S_DONE: begin
                        if (w_out_load) begin
                            r_mdata  <= {6'b0, r_slope, r_value, r_oint};
                            r_muser  <= r_found;
                            r_state  <= S_IDLE;
                        end
                    end
                    default: r_state <= S_IDLE;
                endcase
            end
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_mvalid;
    assign o_m_tdata  = r_mdata;
    assign o_m_tuser  = r_muser;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |=> !o_s_tready)
        else $error("item taken but sequencer still idle");
    a_found_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FOUND && r_found) |-> r_k < r_n)
        else $error("found interval beyond table");
    a_div_only_in_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_req.start |-> w_colok && r_found)
        else $error("division outside an interpolating lookup");

endmodule

`default_nettype wire

/* sv/pvti_div.sv */
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module pvti_div (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  pvti_pkg::t_div_req  i_req,
    output pvti_pkg::t_div_rsp  o_rsp
);

    localparam int NW = pvti_pkg::DIV_NUM_W;
    localparam int DW = pvti_pkg::DIV_DEN_W;
    localparam int QW = pvti_pkg::DIV_Q_W;
    localparam int CW = $clog2(QW + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_den;
    logic [QW-1:0] r_lo;
    logic [QW-1:0] r_quo;
    logic          r_ovf;

    logic [DW:0]   w_rem2;
    logic [DW:0]   w_sub;
    logic          w_ge;

    assign w_rem2 = {r_rem, r_lo[QW-1]};
    assign w_ge   = w_rem2 >= {1'b0, r_den};
    assign w_sub  = w_rem2 - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CW'(1));
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(QW);
                r_rem  <= DW'(i_req.num >> QW);
                r_lo   <= i_req.num[QW-1:0];
                r_den  <= i_req.den;
                r_ovf  <= (i_req.num >> QW) >= NW'(i_req.den);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                end
                r_rem <= w_ge ? w_sub[DW-1:0] : w_rem2[DW-1:0];
                r_lo  <= {r_lo[QW-2:0], 1'b0};
                r_quo <= {r_quo[QW-2:0], w_ge};
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.ovf  = r_ovf;
    assign o_rsp.quo  = r_quo;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> !r_busy)
        else $error("divider started while busy");
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy) && !r_busy)
        else $error("done without a finished pass");
    a_cnt_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_cnt != '0)
        else $error("busy with empty count");

endmodule

`default_nettype wire
